FILE: rtl/adc_range_converter_unit_defines.svh
// Shared assertion macros for the converter checker.
`ifndef ADC_RANGE_CONVERTER_UNIT_DEFINES_SVH
`define ADC_RANGE_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ARC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ARC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/arc_pkg.sv
package arc_pkg;

  localparam int OP_W        = 5;
  localparam int SAMPLE_W    = 10;
  localparam int VALUE_W     = 16;
  localparam int CHAN_W      = 3;
  localparam int TABLE_LEN   = 21;
  localparam int ZERO_SEG    = 5;
  localparam int DIV_NUM_W   = 27;
  localparam int DIV_DEN_W   = 14;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_RAW    = 5'd0;
  localparam logic [OP_W-1:0] OP_T2C    = 5'd1;
  localparam logic [OP_W-1:0] OP_T2F    = 5'd2;
  localparam logic [OP_W-1:0] OP_PCT    = 5'd3;
  localparam logic [OP_W-1:0] OP_ONOFF  = 5'd4;
  localparam logic [OP_W-1:0] OP_OFFON  = 5'd5;
  localparam logic [OP_W-1:0] OP_PASS6  = 5'd6;
  localparam logic [OP_W-1:0] OP_PASS7  = 5'd7;
  localparam logic [OP_W-1:0] OP_T3C    = 5'd8;
  localparam logic [OP_W-1:0] OP_T3F    = 5'd9;
  localparam logic [OP_W-1:0] OP_UNUSED = 5'd10;
  localparam logic [OP_W-1:0] OP_5V     = 5'd11;
  localparam logic [OP_W-1:0] OP_10V    = 5'd12;
  localparam logic [OP_W-1:0] OP_20MA   = 5'd13;
  localparam logic [OP_W-1:0] OP_100MA  = 5'd14;
  localparam logic [OP_W-1:0] OP_LMC    = 5'd15;
  localparam logic [OP_W-1:0] OP_LMF    = 5'd16;

  typedef enum logic [3:0] {
    CLS_RAW, CLS_THERM, CLS_PCT, CLS_SWITCH, CLS_PASS,
    CLS_ZERO, CLS_SCALE, CLS_LM, CLS_BAD
  } cls_t;

  typedef enum logic [1:0] {SC_5V, SC_10V, SC_20MA, SC_100MA} scale_t;

  typedef struct packed {
    cls_t                cls;
    logic                fahr;
    logic                type3;
    logic                on_off;
    scale_t              scale;
    logic [SAMPLE_W-1:0] sample;
    logic [VALUE_W-1:0]  caladj;
    logic [CHAN_W-1:0]   chan;
  } entry_t;

  // Segment widths in ADC counts, 10.0 C per segment.
  function automatic logic [6:0] seg_width(input logic type3, input logic [4:0] idx);
    logic [6:0] w;
    case (idx)
      5'd0:    w = type3 ? 7'd18  : 7'd15;
      5'd1:    w = type3 ? 7'd29  : 7'd25;
      5'd2:    w = type3 ? 7'd45  : 7'd41;
      5'd3:    w = type3 ? 7'd63  : 7'd61;
      5'd4:    w = type3 ? 7'd81  : 7'd83;
      5'd5:    w = type3 ? 7'd96  : 7'd102;
      5'd6:    w = type3 ? 7'd104 : 7'd113;
      5'd7:    w = type3 ? 7'd103 : 7'd112;
      5'd8:    w = type3 ? 7'd94  : 7'd101;
      5'd9:    w = type3 ? 7'd80  : 7'd85;
      5'd10:   w = type3 ? 7'd65  : 7'd67;
      5'd11:   w = 7'd51;
      5'd12:   w = type3 ? 7'd40  : 7'd38;
      5'd13:   w = type3 ? 7'd30  : 7'd28;
      5'd14:   w = type3 ? 7'd23  : 7'd21;
      5'd15:   w = type3 ? 7'd17  : 7'd15;
      5'd16:   w = type3 ? 7'd13  : 7'd11;
      5'd17:   w = type3 ? 7'd10  : 7'd8;
      5'd18:   w = type3 ? 7'd8   : 7'd6;
      5'd19:   w = type3 ? 7'd6   : 7'd5;
      5'd20:   w = type3 ? 7'd24  : 7'd19;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/arc_front.sv
module arc_front #(
  parameter int CHANNELS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [arc_pkg::OP_W-1:0]     op,
  input  logic [arc_pkg::SAMPLE_W-1:0] sample,
  input  logic [arc_pkg::VALUE_W-1:0]  calibration,
  input  logic [arc_pkg::CHAN_W-1:0]   channel,
  input  logic                         cfg_we,
  input  logic [arc_pkg::VALUE_W-1:0]  cfg_data,
  input  logic                         q_full,
  output logic                         q_push,
  output arc_pkg::entry_t              q_entry
);
  import arc_pkg::*;

  logic [VALUE_W-1:0] cal_offset;
  logic [CHAN_W-1:0]  chan_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset <= '0;
    end else if (cfg_we) begin
      cal_offset <= cfg_data;
    end
  end

  assign full   = q_full;
  assign q_push = push & ~q_full;

  // channel modulo CHANNELS, eight conditional subtracts
  always_comb begin
    chan_wrap = channel;
    for (int i = 0; i < 8; i++) begin
      if (int'(chan_wrap) >= CHANNELS) begin
        chan_wrap = chan_wrap - CHAN_W'(CHANNELS);
      end
    end
  end

  always_comb begin
    q_entry        = '0;
    q_entry.sample = sample;
    q_entry.caladj = calibration - cal_offset;
    q_entry.chan   = chan_wrap;
    q_entry.cls    = CLS_BAD;
    q_entry.scale  = SC_5V;
    case (op)
      OP_RAW:    q_entry.cls = CLS_RAW;
      OP_T2C:    q_entry.cls = CLS_THERM;
      OP_T2F: begin
        q_entry.cls  = CLS_THERM;
        q_entry.fahr = 1'b1;
      end
      OP_T3C: begin
        q_entry.cls   = CLS_THERM;
        q_entry.type3 = 1'b1;
      end
      OP_T3F: begin
        q_entry.cls   = CLS_THERM;
        q_entry.type3 = 1'b1;
        q_entry.fahr  = 1'b1;
      end
      OP_PCT:    q_entry.cls = CLS_PCT;
      OP_ONOFF: begin
        q_entry.cls    = CLS_SWITCH;
        q_entry.on_off = 1'b1;
      end
      OP_OFFON:  q_entry.cls = CLS_SWITCH;
      OP_PASS6, OP_PASS7: q_entry.cls = CLS_PASS;
      OP_UNUSED: q_entry.cls = CLS_ZERO;
      OP_5V: begin
        q_entry.cls   = CLS_SCALE;
        q_entry.scale = SC_5V;
      end
      OP_10V: begin
        q_entry.cls   = CLS_SCALE;
        q_entry.scale = SC_10V;
      end
      OP_20MA: begin
        q_entry.cls   = CLS_SCALE;
        q_entry.scale = SC_20MA;
      end
      OP_100MA: begin
        q_entry.cls   = CLS_SCALE;
        q_entry.scale = SC_100MA;
      end
      OP_LMC:    q_entry.cls = CLS_LM;
      OP_LMF: begin
        q_entry.cls  = CLS_LM;
        q_entry.fahr = 1'b1;
      end
      default:   q_entry.cls = CLS_BAD;
    endcase
  end

endmodule

FILE: rtl/arc_queue.sv
module arc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  arc_pkg::entry_t wr_data,
  input  logic            rd_en,
  output arc_pkg::entry_t rd_data,
  output logic            full,
  output logic            empty
);
  import arc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t        mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/arc_div.sv
module arc_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [arc_pkg::DIV_NUM_W-1:0] num,
  input  logic        [arc_pkg::DIV_DEN_W-1:0] den,
  output logic                                 done,
  output logic signed [arc_pkg::DIV_NUM_W-1:0] quot
);
  import arc_pkg::*;

  // restoring divider, one quotient bit per cycle, truncates toward zero
  logic [4:0]           cnt;
  logic                 busy;
  logic                 neg;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_NUM_W-1:0] mag;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] diff;
  logic                 ge;

  assign shifted = {rem[DIV_DEN_W-1:0], mag[DIV_NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign ge      = ~diff[DIV_DEN_W+1];
  assign quot    = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIV_NUM_W);
        rem  <= '0;
        neg  <= num[DIV_NUM_W-1];
        mag  <= num[DIV_NUM_W-1] ? 27'(-num) : 27'(num);
      end else if (busy) begin
        rem <= ge ? diff[DIV_DEN_W:0] : shifted;
        mag <= {mag[DIV_NUM_W-2:0], ge};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/arc_back.sv
module arc_back #(
  parameter int CHANNELS = 8,
  parameter int SEGMENTS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_rd,
  input  arc_pkg::entry_t             q_data,
  input  logic                        pop,
  output logic                        empty,
  output logic [arc_pkg::VALUE_W-1:0] value,
  output logic                        unsupported
);
  import arc_pkg::*;

  localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int START_IDX = (SEGMENTS < TABLE_LEN) ? SEGMENTS : TABLE_LEN - 1;

  // constant divides by reciprocal multiply: q = (x * ceil(2^k / d)) >> k,
  // exact over the numerator ranges seen here
  localparam logic [24:0] RECIP_1023  = 25'd131201;    // k = 27, x < 2^17
  localparam logic [24:0] RECIP_10000 = 25'd27487791;  // k = 38, x < 2^25
  localparam logic [24:0] RECIP_5     = 25'd26215;     // k = 17, x < 2^15
  localparam logic [25:0] LM_SCALE    = 26'd48876;
  localparam logic [25:0] LM_ZERO     = 26'd27320000;

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_SEARCH, B_TEMP, B_DIV, B_RECIP, B_POST, B_OUT
  } state_t;
  typedef enum logic [1:0] {P_FAHR, P_PCT, P_BAND, P_LM} post_t;

  state_t                      state;
  post_t                       post;
  entry_t                      ent;
  logic [4:0]                  idx;
  logic [11:0]                 acc;
  logic                        first;
  logic signed [12:0]          temp;
  logic [VALUE_W-1:0]          res;
  logic                        res_unsup;
  logic                        out_valid;
  logic [CHANNELS-1:0]         sw;
  logic                        div_start;
  logic signed [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0]        div_den;
  logic                        div_done;
  logic signed [DIV_NUM_W-1:0] div_q;
  logic [24:0]                 rnum;
  logic                        rneg;
  logic [VALUE_W-1:0]          rq;

  logic [6:0]          w_cur;
  logic [6:0]          w_prev;
  logic                hit;
  logic signed [12:0]  seg_tenths;
  logic [CW-1:0]       ch;
  logic [5:0]          band;
  logic                new_bit;
  logic [DIV_NUM_W-1:0] scaled;
  logic [25:0]         lm_prod;
  logic                lm_neg;
  logic [24:0]         lm_mag;
  logic [VALUE_W-1:0]  rq_mag;
  logic [12:0]         temp_mag;
  logic [24:0]         r_const;
  logic [49:0]         r_prod;
  logic [VALUE_W-1:0]  r_quot;

  arc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign q_rd       = (state == B_IDLE) && !q_empty;
  assign empty      = ~out_valid;
  assign w_cur      = seg_width(ent.type3, idx);
  assign w_prev     = seg_width(ent.type3, idx - 5'd1);
  assign hit        = acc > {2'b00, ent.sample};
  assign seg_tenths = 13'((int'(idx) - ZERO_SEG) * 100);
  assign ch         = CW'(ent.chan);
  assign band       = rq[5:0];

  // LM235 numerator split into sign and magnitude
  assign lm_prod  = 26'(q_data.sample) * LM_SCALE;
  assign lm_neg   = lm_prod < LM_ZERO;
  assign lm_mag   = lm_neg ? 25'(LM_ZERO - lm_prod) : 25'(lm_prod - LM_ZERO);
  assign rq_mag   = rq[VALUE_W-1] ? -rq : rq;
  assign temp_mag = temp[12] ? 13'(-temp) : 13'(temp);

  always_comb begin
    if (band <= 6'd24) begin
      new_bit = ~ent.on_off;
    end else if (band >= 6'd26) begin
      new_bit = ent.on_off;
    end else begin
      new_bit = sw[ch];
    end
  end

  always_comb begin
    case (q_data.scale)
      SC_5V:    scaled = DIV_NUM_W'(int'(q_data.sample) * 5000);
      SC_10V:   scaled = DIV_NUM_W'(int'(q_data.sample) * 10000);
      SC_20MA:  scaled = DIV_NUM_W'(int'(q_data.sample) * 2000);
      SC_100MA: scaled = DIV_NUM_W'(int'(q_data.sample) * 100000);
      default:  scaled = '0;
    endcase
  end

  always_comb begin
    case (post)
      P_LM:    r_const = RECIP_10000;
      P_FAHR:  r_const = RECIP_5;
      default: r_const = RECIP_1023;
    endcase
  end

  assign r_prod = 50'(rnum) * 50'(r_const);

  always_comb begin
    case (post)
      P_LM:    r_quot = VALUE_W'(r_prod[49:38]);
      P_FAHR:  r_quot = r_prod[32:17];
      default: r_quot = r_prod[42:27];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      sw        <= '0;
    end else begin
      div_start <= (state == B_SEARCH) && hit && !first;
      if (state == B_OUT && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_LOAD;
          end
        end
        B_LOAD: begin
          ent       <= q_data;
          res_unsup <= (q_data.cls == CLS_BAD);
          case (q_data.cls)
            CLS_RAW: begin
              res   <= VALUE_W'(q_data.sample) + q_data.caladj;
              state <= B_OUT;
            end
            CLS_PASS: begin
              res   <= VALUE_W'(q_data.sample);
              state <= B_OUT;
            end
            CLS_SCALE: begin
              res   <= scaled[VALUE_W+9:10];
              state <= B_OUT;
            end
            CLS_THERM: begin
              idx   <= 5'(START_IDX);
              acc   <= 12'(seg_width(q_data.type3, 5'(START_IDX)));
              first <= 1'b1;
              state <= B_SEARCH;
            end
            CLS_PCT: begin
              rnum  <= 25'(q_data.sample) * 25'd100;
              rneg  <= 1'b0;
              post  <= P_PCT;
              state <= B_RECIP;
            end
            CLS_SWITCH: begin
              rnum  <= 25'(q_data.sample) * 25'd50;
              rneg  <= 1'b0;
              post  <= P_BAND;
              state <= B_RECIP;
            end
            CLS_LM: begin
              rnum  <= lm_mag;
              rneg  <= lm_neg;
              post  <= P_LM;
              state <= B_RECIP;
            end
            default: begin
              res   <= '0;
              state <= B_OUT;
            end
          endcase
        end
        B_SEARCH: begin
          if (hit) begin
            if (first) begin
              temp  <= seg_tenths;
              state <= B_TEMP;
            end else begin
              div_num <= DIV_NUM_W'((int'(acc) - int'(ent.sample)) * 100);
              div_den <= DIV_DEN_W'(w_cur);
              state   <= B_DIV;
            end
          end else if (idx == 5'd0) begin
            temp  <= -13'sd1000;
            state <= B_TEMP;
          end else begin
            idx   <= idx - 5'd1;
            acc   <= acc + 12'(w_prev);
            first <= 1'b0;
          end
        end
        B_TEMP: begin
          if (ent.fahr) begin
            rnum  <= 25'(temp_mag) * 25'd9;
            rneg  <= temp[12];
            post  <= P_FAHR;
            state <= B_RECIP;
          end else begin
            res   <= VALUE_W'(temp) + ent.caladj;
            state <= B_OUT;
          end
        end
        B_DIV: begin
          // segment interpolation only
          if (div_done && !div_start) begin
            temp  <= 13'(div_q) + seg_tenths;
            state <= B_TEMP;
          end
        end
        B_RECIP: begin
          rq    <= rneg ? -r_quot : r_quot;
          state <= B_POST;
        end
        B_POST: begin
          case (post)
            P_FAHR: begin
              res   <= rq + VALUE_W'(320) +
                       ((ent.cls == CLS_THERM) ? ent.caladj : '0);
              state <= B_OUT;
            end
            P_PCT: begin
              res   <= rq;
              state <= B_OUT;
            end
            P_BAND: begin
              sw[ch] <= new_bit;
              res    <= VALUE_W'(new_bit);
              state  <= B_OUT;
            end
            P_LM: begin
              if (ent.fahr) begin
                rnum  <= 25'(rq_mag) * 25'd9;
                rneg  <= rq[VALUE_W-1];
                post  <= P_FAHR;
                state <= B_RECIP;
              end else begin
                res   <= rq;
                state <= B_OUT;
              end
            end
            default: state <= B_OUT;
          endcase
        end
        B_OUT: begin
          if (!out_valid || pop) begin
            value       <= res;
            unsupported <= res_unsup;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/adc_range_converter_unit.sv
// Channel   Direction  Handshake           Word
// input     in         push / full         op, sample, calibration, channel
// result    out        pop / empty         value, unsupported
// config    in         cfg_we (no wait)    cfg_data -> calibration offset
//
// Flow: an item passes the input queue, then the back end works it alone.
// Raw, pass, scaling and unknown modes go from load straight to output;
// percent, on/off and LM235 C pass the reciprocal and post steps, LM235 F
// twice (reciprocal multiplies for constant divides). Thermistors take up
// to 21 search steps plus a bit-serial divide for the segment interpolation.
// Reset clears the queue, the result valid flag, the offset and switch states.
// A full queue stalls push; an untaken result stalls the back end only.
module adc_range_converter_unit #(
  parameter int CHANNELS = 8,
  parameter int SEGMENTS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [arc_pkg::OP_W-1:0]     op,
  input  logic [arc_pkg::SAMPLE_W-1:0] sample,
  input  logic [arc_pkg::VALUE_W-1:0]  calibration,
  input  logic [arc_pkg::CHAN_W-1:0]   channel,
  input  logic                         pop,
  output logic                         empty,
  output logic [arc_pkg::VALUE_W-1:0]  value,
  output logic                         unsupported,
  input  logic                         cfg_we,
  input  logic [arc_pkg::VALUE_W-1:0]  cfg_data
);
  import arc_pkg::*;

  entry_t q_entry;
  entry_t q_data;
  logic   q_push;
  logic   q_full;
  logic   q_empty;
  logic   q_rd;

  // front: offset register and mode decode
  arc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .sample      (sample),
    .calibration (calibration),
    .channel     (channel),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // decoupling queue between decode and conversion
  arc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_entry),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: table search, divider, hysteresis, result register
  arc_back #(.CHANNELS(CHANNELS), .SEGMENTS(SEGMENTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .q_data      (q_data),
    .pop         (pop),
    .empty       (empty),
    .value       (value),
    .unsupported (unsupported)
  );

endmodule

FILE: rtl/arc_checker.sv
`include "adc_range_converter_unit_defines.svh"

module arc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input logic                        pop,
  input logic                        empty,
  input logic [arc_pkg::VALUE_W-1:0] value,
  input logic                        unsupported
);

  `ARC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(value) && $stable(unsupported), "result word changed before pop")
  `ARC_ASSERT_NOW(a_unsup_zero, !empty && unsupported, value == '0, "unsupported mode with nonzero value")
  `ARC_ASSERT_NOW(a_reset_empty, $fell(rst), empty && !full, "not empty after reset")

endmodule

bind adc_range_converter_unit arc_checker u_chk (.*);
